@@ rtl/core/bfpa_pkg.sv @@
`timescale 1ns / 1ps

package bfpa_pkg;

  // Fixed field widths of the request and result beats.
  localparam int REQ_W = 16;
  localparam int BA_W  = 12;
  localparam int RES_W = 12;

  // Default configuration of the pool.
  localparam int DEF_POOL_SIZE   = 4096;
  localparam int DEF_HEADER_SIZE = 16;
  localparam int DEF_MAX_BLOCKS  = 256;

  // Request codes.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_NO_FIT    = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic              mode;
    logic [REQ_W-1:0]  request_size;
    logic [BA_W-1:0]   block_address;
  } in_item_t;

  typedef struct packed {
    logic [RES_W-1:0]  result_address;
    status_t           status;
  } out_item_t;

  // Finished result handed from the engine to the output stage.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHUP_RD,
    S_SHUP_WR,
    S_INS_LO,
    S_INS_HI,
    S_F_LO,
    S_F_LOW,
    S_F_HI,
    S_F_HIW,
    S_MERGE,
    S_SHDN_RD,
    S_SHDN_WR,
    S_RESP
  } state_t;

endpackage

@@ rtl/core/bfpa_ram.sv @@
`timescale 1ns / 1ps

module bfpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/bfpa_out_stage.sv @@
`timescale 1ns / 1ps

module bfpa_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  bfpa_pkg::res_t      res,
  output logic                res_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output bfpa_pkg::out_item_t out_data
);
  import bfpa_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // The register takes a new result when empty or being drained this cycle.
  assign res_ready     = !out_valid_r || out_ready;
  assign out_valid_nxt = (res.valid && res_ready) || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_data_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/core/bfpa_engine.sv @@
`timescale 1ns / 1ps

module bfpa_engine #(
  parameter int POOL_SIZE   = bfpa_pkg::DEF_POOL_SIZE,
  parameter int HEADER_SIZE = bfpa_pkg::DEF_HEADER_SIZE,
  parameter int MAX_BLOCKS  = bfpa_pkg::DEF_MAX_BLOCKS,
  parameter int IDX_W       = $clog2(MAX_BLOCKS),
  parameter int ENT_W       = 2 * $clog2(POOL_SIZE) + 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bfpa_pkg::in_item_t in_data,
  output bfpa_pkg::res_t     res,
  input  logic               res_ready,
  output logic               wr_en,
  output logic [IDX_W-1:0]   wr_addr,
  output logic [ENT_W-1:0]   wr_data,
  output logic               rd_en,
  output logic [IDX_W-1:0]   rd_addr,
  input  logic [ENT_W-1:0]   rd_data
);
  import bfpa_pkg::*;

  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int ADDR_W = $clog2(POOL_SIZE);
  localparam int SIZE_W = ADDR_W + 1;
  localparam int CW     = ((SIZE_W > REQ_W) ? SIZE_W : REQ_W) + 2;
  localparam int MW     = ((ADDR_W > BA_W) ? ADDR_W : BA_W);

  localparam logic [CW-1:0]    HDR_C  = CW'(HEADER_SIZE);
  localparam logic [CW-1:0]    POOL_C = CW'(POOL_SIZE);
  localparam logic [CNT_W-1:0] MAX_C  = CNT_W'(MAX_BLOCKS);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   pidx_r, pidx_nxt;
  logic               found_r, found_nxt;
  logic [1:0]         d_r, d_nxt;

  logic               mode_r, mode_nxt;
  logic [REQ_W-1:0]   req_r, req_nxt;
  logic [BA_W-1:0]    where_r, where_nxt;
  logic [IDX_W-1:0]   best_r, best_nxt;
  logic [ADDR_W-1:0]  best_start_r, best_start_nxt;
  logic [SIZE_W-1:0]  best_size_r, best_size_nxt;
  logic               lo_free_r, lo_free_nxt;
  logic [SIZE_W-1:0]  lo_size_r, lo_size_nxt;
  logic               hi_free_r, hi_free_nxt;
  logic [ADDR_W-1:0]  hi_start_r, hi_start_nxt;
  logic [SIZE_W-1:0]  hi_size_r, hi_size_nxt;
  logic [RES_W-1:0]   res_addr_r, res_addr_nxt;
  status_t            res_status_r, res_status_nxt;

  logic               rd_used;
  logic [SIZE_W-1:0]  rd_size;
  logic [ADDR_W-1:0]  rd_start;
  logic [CW-1:0]      req_w;
  logic [CW-1:0]      merge_size;
  logic [CNT_W-1:0]   best_c;
  logic [IDX_W-1:0]   lo_idx;

  // Entry layout: used flag, size, start.
  assign rd_used  = rd_data[ENT_W-1];
  assign rd_size  = rd_data[ENT_W-2 -: SIZE_W];
  assign rd_start = rd_data[ADDR_W-1:0];
  assign req_w    = CW'(req_r);
  assign best_c   = CNT_W'(best_r);
  assign lo_idx   = lo_free_r ? (best_r - IDX_W'(1)) : best_r;

  // Size of the merged free run.
  assign merge_size = CW'(best_size_r)
                    + (lo_free_r ? (CW'(lo_size_r) + HDR_C) : '0)
                    + (hi_free_r ? (CW'(hi_size_r) + HDR_C) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      count_r <= CNT_W'(1);
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    k_r          <= k_nxt;
    pidx_r       <= pidx_nxt;
    found_r      <= found_nxt;
    d_r          <= d_nxt;
    mode_r       <= mode_nxt;
    req_r        <= req_nxt;
    where_r      <= where_nxt;
    best_r       <= best_nxt;
    best_start_r <= best_start_nxt;
    best_size_r  <= best_size_nxt;
    lo_free_r    <= lo_free_nxt;
    lo_size_r    <= lo_size_nxt;
    hi_free_r    <= hi_free_nxt;
    hi_start_r   <= hi_start_nxt;
    hi_size_r    <= hi_size_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
  end

  // Sequencer: scan, then split/insert or merge/remove through the table memory.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    k_nxt          = k_r;
    pend_nxt       = pend_r;
    pidx_nxt       = pidx_r;
    found_nxt      = found_r;
    d_nxt          = d_r;
    mode_nxt       = mode_r;
    req_nxt        = req_r;
    where_nxt      = where_r;
    best_nxt       = best_r;
    best_start_nxt = best_start_r;
    best_size_nxt  = best_size_r;
    lo_free_nxt    = lo_free_r;
    lo_size_nxt    = lo_size_r;
    hi_free_nxt    = hi_free_r;
    hi_start_nxt   = hi_start_r;
    hi_size_nxt    = hi_size_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    in_ready       = 1'b0;
    res.valid      = 1'b0;
    res.item       = '{result_address: res_addr_r, status: res_status_r};
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;

    unique case (state_r)
      S_INIT: begin
        // One free block covering the pool.
        wr_en     = 1'b1;
        wr_data   = {1'b0, SIZE_W'(POOL_SIZE - HEADER_SIZE), ADDR_W'(0)};
        count_nxt = CNT_W'(1);
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt       = in_data.mode;
          req_nxt        = in_data.request_size;
          where_nxt      = in_data.block_address;
          idx_nxt        = '0;
          pend_nxt       = 1'b0;
          found_nxt      = 1'b0;
          res_addr_nxt   = '0;
          res_status_nxt = ST_OK;
          if (in_data.mode == MODE_ALLOC &&
              (in_data.request_size == '0 ||
               CW'(in_data.request_size) >= POOL_C)) begin
            res_status_nxt = ST_BAD_SIZE;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue one read a cycle; the data of the previous read is examined.
        if (idx_r < count_r) begin
          rd_en    = 1'b1;
          rd_addr  = idx_r[IDX_W-1:0];
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[IDX_W-1:0];
          idx_nxt  = idx_r + CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (mode_r == MODE_ALLOC) begin
            if (!rd_used && req_w <= CW'(rd_size) &&
                (!found_r || rd_size < best_size_r)) begin
              found_nxt      = 1'b1;
              best_nxt       = pidx_r;
              best_start_nxt = rd_start;
              best_size_nxt  = rd_size;
            end
          end else if (MW'(rd_start) == MW'(where_r)) begin
            best_nxt       = pidx_r;
            best_start_nxt = rd_start;
            best_size_nxt  = rd_size;
            pend_nxt       = 1'b0;
            if (!rd_used) begin
              res_status_nxt = ST_NOT_FOUND;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_F_LO;
            end
          end
        end else if (idx_r >= count_r) begin
          if (mode_r == MODE_ALLOC) begin
            state_nxt = S_DECIDE;
          end else begin
            res_status_nxt = ST_NOT_FOUND;
            state_nxt      = S_RESP;
          end
        end
      end

      S_DECIDE: begin
        if (!found_r) begin
          res_status_nxt = ST_NO_FIT;
          state_nxt      = S_RESP;
        end else if (req_w + HDR_C >= CW'(best_size_r)) begin
          // Spare space within one header: the whole block is taken.
          wr_en        = 1'b1;
          wr_addr      = best_r;
          wr_data      = {1'b1, best_size_r, best_start_r};
          res_addr_nxt = RES_W'(MW'(best_start_r));
          state_nxt    = S_RESP;
        end else if (count_r >= MAX_C) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_RESP;
        end else if (best_c + CNT_W'(1) < count_r) begin
          k_nxt     = count_r - CNT_W'(1);
          state_nxt = S_SHUP_RD;
        end else begin
          state_nxt = S_INS_LO;
        end
      end

      S_SHUP_RD: begin
        rd_en     = 1'b1;
        rd_addr   = k_r[IDX_W-1:0];
        state_nxt = S_SHUP_WR;
      end

      S_SHUP_WR: begin
        // Move the entry up one place to open a slot after the chosen block.
        wr_en   = 1'b1;
        wr_addr = IDX_W'(k_r + CNT_W'(1));
        wr_data = rd_data;
        if (k_r == best_c + CNT_W'(1)) begin
          state_nxt = S_INS_LO;
        end else begin
          k_nxt     = k_r - CNT_W'(1);
          state_nxt = S_SHUP_RD;
        end
      end

      S_INS_LO: begin
        wr_en     = 1'b1;
        wr_addr   = best_r + IDX_W'(1);
        wr_data   = {1'b1, req_w[SIZE_W-1:0], best_start_r};
        state_nxt = S_INS_HI;
      end

      S_INS_HI: begin
        // The free remainder sits above the new used block.
        wr_en        = 1'b1;
        wr_addr      = best_r;
        wr_data      = {1'b0,
                        SIZE_W'(CW'(best_size_r) - req_w - HDR_C),
                        ADDR_W'(CW'(best_start_r) + req_w + HDR_C)};
        count_nxt    = count_r + CNT_W'(1);
        res_addr_nxt = RES_W'(MW'(best_start_r));
        state_nxt    = S_RESP;
      end

      S_F_LO: begin
        if (best_r != '0) begin
          rd_en     = 1'b1;
          rd_addr   = best_r - IDX_W'(1);
          state_nxt = S_F_LOW;
        end else begin
          lo_free_nxt = 1'b0;
          state_nxt   = S_F_HI;
        end
      end

      S_F_LOW: begin
        lo_free_nxt = !rd_used;
        lo_size_nxt = rd_size;
        state_nxt   = S_F_HI;
      end

      S_F_HI: begin
        if (best_c + CNT_W'(1) < count_r) begin
          rd_en     = 1'b1;
          rd_addr   = best_r + IDX_W'(1);
          state_nxt = S_F_HIW;
        end else begin
          hi_free_nxt = 1'b0;
          state_nxt   = S_MERGE;
        end
      end

      S_F_HIW: begin
        hi_free_nxt  = !rd_used;
        hi_start_nxt = rd_start;
        hi_size_nxt  = rd_size;
        state_nxt    = S_MERGE;
      end

      S_MERGE: begin
        // The run collapses into its first entry, taking the last entry's start.
        wr_en   = 1'b1;
        wr_addr = lo_idx;
        wr_data = {1'b0, merge_size[SIZE_W-1:0],
                   hi_free_r ? hi_start_r : best_start_r};
        d_nxt   = {1'b0, lo_free_r} + {1'b0, hi_free_r};
        k_nxt   = best_c + CNT_W'(hi_free_r) + CNT_W'(1);
        if (!lo_free_r && !hi_free_r) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_SHDN_RD;
        end
      end

      S_SHDN_RD: begin
        if (k_r < count_r) begin
          rd_en     = 1'b1;
          rd_addr   = k_r[IDX_W-1:0];
          state_nxt = S_SHDN_WR;
        end else begin
          count_nxt = count_r - CNT_W'(d_r);
          state_nxt = S_RESP;
        end
      end

      S_SHDN_WR: begin
        // Close the gap left by the absorbed entries.
        wr_en     = 1'b1;
        wr_addr   = IDX_W'(k_r - CNT_W'(d_r));
        wr_data   = rd_data;
        k_nxt     = k_r + CNT_W'(1);
        state_nxt = S_SHDN_RD;
      end

      S_RESP: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The table never empties and never exceeds its capacity.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_INIT) |-> (count_r >= CNT_W'(1) && count_r <= MAX_C))
    else $error("entry count out of range");

  // An accepted beat always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted beat not taken up");

  // Writes stay within the live table plus the slot opened by a split.
  a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (CNT_W'(wr_addr) <= count_r))
    else $error("table write beyond live entries");

  // Entries are removed only after a merge of at most two neighbours.
  a_merge_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHDN_WR) |-> (d_r == 2'd1 || d_r == 2'd2))
    else $error("bad merge depth");

endmodule

@@ rtl/core/best_fit_pool_allocator_unit.sv @@
`timescale 1ns / 1ps

// Best-fit pool allocator. Each request beat is either an allocate (best-fit
// search with block splitting) or a free (lookup and merging of neighbouring
// free blocks), and yields exactly one result beat. The block table lives in
// a single-port-write, registered-read memory, and every step goes through
// that memory one entry per access: the search reads the entries in order,
// a split moves every entry after the chosen block up one place, and a merge
// moves the entries after the merged run down, with one read and one write
// per moved entry. One item is handled at a time; the output register lets
// the next beat be accepted while a result is still waiting. After reset the
// table is set up in the init state before the first beat is accepted.
module best_fit_pool_allocator_unit #(
  parameter int POOL_SIZE   = bfpa_pkg::DEF_POOL_SIZE,
  parameter int HEADER_SIZE = bfpa_pkg::DEF_HEADER_SIZE,
  parameter int MAX_BLOCKS  = bfpa_pkg::DEF_MAX_BLOCKS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bfpa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bfpa_pkg::out_item_t out_data
);
  import bfpa_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int ENT_W = 2 * $clog2(POOL_SIZE) + 2;

  res_t             res;
  logic             res_ready;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [ENT_W-1:0] rd_data;

  // Block table.
  bfpa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Search, split and merge sequencer.
  bfpa_engine #(
    .POOL_SIZE   (POOL_SIZE),
    .HEADER_SIZE (HEADER_SIZE),
    .MAX_BLOCKS  (MAX_BLOCKS),
    .IDX_W       (IDX_W),
    .ENT_W       (ENT_W)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res       (res),
    .res_ready (res_ready),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // Result register.
  bfpa_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ tb/bfpa_checker.sv @@
`timescale 1ns / 1ps

module bfpa_checker #(
  parameter int POOL_SIZE   = bfpa_pkg::DEF_POOL_SIZE,
  parameter int HEADER_SIZE = bfpa_pkg::DEF_HEADER_SIZE,
  parameter int MAX_BLOCKS  = bfpa_pkg::DEF_MAX_BLOCKS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  bfpa_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  bfpa_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);
  import bfpa_pkg::*;

  // Shadow copy of the block table.
  int unsigned blk_start [MAX_BLOCKS];
  int unsigned blk_size  [MAX_BLOCKS];
  bit          blk_used  [MAX_BLOCKS];
  int unsigned blk_count;

  out_item_t expected_results[$];

  assign pending = expected_results.size();

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic void table_reset();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      blk_start[i] = 0;
      blk_size[i]  = 0;
      blk_used[i]  = 0;
    end
    blk_size[0] = POOL_SIZE - HEADER_SIZE;
    blk_count   = 1;
  endfunction

  function automatic void drop_block(int unsigned k);
    for (int unsigned j = k; j + 1 < blk_count; j++) begin
      blk_start[j] = blk_start[j+1];
      blk_size[j]  = blk_size[j+1];
      blk_used[j]  = blk_used[j+1];
    end
    blk_count--;
  endfunction

  // Merges every run of neighbouring free blocks into its first block.
  function automatic void merge_free_runs();
    int unsigned i;
    i = 0;
    while (i + 1 < blk_count) begin
      if (!blk_used[i] && !blk_used[i+1]) begin
        blk_start[i] = blk_start[i+1];
        blk_size[i]  = blk_size[i] + blk_size[i+1] + HEADER_SIZE;
        drop_block(i + 1);
      end else begin
        i++;
      end
    end
  endfunction

  function automatic out_item_t predict_allocation(in_item_t req);
    out_item_t   res;
    int unsigned sz;
    int unsigned best;
    bit          found;
    res.result_address = '0;
    res.status = ST_OK;
    if (req.mode == MODE_FREE) begin
      res.status = ST_NOT_FOUND;
      for (int unsigned i = 0; i < blk_count; i++) begin
        if (blk_start[i] == req.block_address) begin
          if (blk_used[i]) begin
            blk_used[i] = 0;
            merge_free_runs();
            res.status = ST_OK;
          end
          break;
        end
      end
      return res;
    end
    sz = req.request_size;
    if (sz == 0 || sz >= POOL_SIZE) begin
      res.status = ST_BAD_SIZE;
      return res;
    end
    found = 0;
    best  = 0;
    for (int unsigned i = 0; i < blk_count; i++) begin
      if (!blk_used[i] && sz <= blk_size[i] && (!found || blk_size[i] < blk_size[best])) begin
        best  = i;
        found = 1;
      end
    end
    if (!found) begin
      res.status = ST_NO_FIT;
      return res;
    end
    if (sz + HEADER_SIZE >= blk_size[best]) begin
      blk_used[best] = 1;
      res.result_address = blk_start[best][RES_W-1:0];
      return res;
    end
    if (blk_count >= MAX_BLOCKS) begin
      res.status = ST_FULL;
      return res;
    end
    for (int unsigned j = blk_count; j > best + 1; j--) begin
      blk_start[j] = blk_start[j-1];
      blk_size[j]  = blk_size[j-1];
      blk_used[j]  = blk_used[j-1];
    end
    blk_start[best+1] = blk_start[best];
    blk_size[best+1]  = sz;
    blk_used[best+1]  = 1;
    blk_count++;
    res.result_address = blk_start[best][RES_W-1:0];
    blk_start[best] = blk_start[best] + sz + HEADER_SIZE;
    blk_size[best]  = blk_size[best] - sz - HEADER_SIZE;
    return res;
  endfunction

  // Predict on accepted request beats, compare on accepted result beats.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      table_reset();
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(predict_allocation(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (out_data.result_address !== want.result_address)
            report_mismatch($sformatf("result_address %0h, expected %0h",
                                      out_data.result_address, want.result_address));
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_data.status, want.status));
        end
      end
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import bfpa_pkg::*;

  localparam int LIMIT_CYCLES = 10000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        cycle_count = 0;
  bit        calm = 1'b0;

  // Addresses handed out so far, used to build well-formed frees.
  logic [BA_W-1:0] live_blocks[$];

  always #10 clk = ~clk;

  best_fit_pool_allocator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  bfpa_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Collect nonzero addresses of successful allocations.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready && out_data.status == ST_OK &&
        out_data.result_address != 0)
      live_blocks.push_back(out_data.result_address);
  end

  // Receiver stalls in random bursts.
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 4);
        out_ready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Valid stays high from one beat to the next unless an idle burst comes between.
  task automatic send_beat(input logic mode, input logic [REQ_W-1:0] sz,
                           input logic [BA_W-1:0] addr);
    in_item_t item;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item.mode = mode;
    item.request_size = sz;
    item.block_address = addr;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random_beat();
    int pick;
    int k;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if ($urandom_range(0, 3) == 0)
        send_beat(MODE_ALLOC, REQ_W'($urandom_range(1, 600)), BA_W'($urandom));
      else
        send_beat(MODE_ALLOC, REQ_W'($urandom_range(1, 64)), BA_W'($urandom));
    end else if (pick < 85 && live_blocks.size() > 0) begin
      k = $urandom_range(0, live_blocks.size() - 1);
      send_beat(MODE_FREE, REQ_W'($urandom), live_blocks[k]);
      live_blocks.delete(k);
    end else if (pick < 92) begin
      send_beat(MODE_FREE, REQ_W'($urandom), BA_W'($urandom));
    end else begin
      send_beat(MODE_ALLOC, REQ_W'($urandom), BA_W'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, bad sizes, exact fit, splits, bad frees.
    send_beat(MODE_ALLOC, 16'd0, 12'hfff);
    send_beat(MODE_ALLOC, 16'hffff, 12'h000);
    send_beat(MODE_ALLOC, 16'd4096, 12'h000);
    send_beat(MODE_ALLOC, 16'd4095, 12'h000);
    send_beat(MODE_FREE, 16'hffff, 12'h000);
    send_beat(MODE_ALLOC, 16'd1, 12'h000);
    send_beat(MODE_ALLOC, 16'd100, 12'h000);
    send_beat(MODE_FREE, 16'h0000, 12'hfff);
    send_beat(MODE_ALLOC, 16'd3900, 12'h000);
    send_beat(MODE_FREE, 16'h0000, 12'h000);
    send_beat(MODE_FREE, 16'h0000, 12'h000);
    send_beat(MODE_FREE, 16'h0000, 12'd17);
    send_beat(MODE_ALLOC, 16'd4080, 12'h000);
    send_beat(MODE_FREE, 16'h0000, 12'h000);
    send_beat(MODE_ALLOC, 16'd4064, 12'h000);
    send_beat(MODE_FREE, 16'h0000, 12'h000);
    // Fill the pool with tiny splits until it runs out of space.
    for (int i = 0; i < 250; i++)
      send_beat(MODE_ALLOC, 16'd1, 12'h000);
    send_beat(MODE_ALLOC, 16'd200, 12'h000);
    send_beat(MODE_ALLOC, 16'd1, 12'h000);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < 300; i++)
      send_beat(MODE_FREE, 16'h0000, BA_W'(i * 17));
    in_valid <= 1'b0;
    live_blocks.delete();

    // Random part; the last stretch runs without idling.
    for (int i = 0; i < 580; i++) begin
      if (i == 480) calm = 1'b1;
      send_random_beat();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/bfpa_pkg.sv
rtl/core/bfpa_ram.sv
rtl/core/bfpa_out_stage.sv
rtl/core/bfpa_engine.sv
rtl/core/best_fit_pool_allocator_unit.sv
tb/bfpa_checker.sv
tb/tb.sv
